### sv/md5_pkg.sv
package md5_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } state_t;

    localparam int WORD_W  = 32;
    localparam int COUNT_W = 61;

    localparam logic [WORD_W-1:0] INIT_A = 32'h67452301;
    localparam logic [WORD_W-1:0] INIT_B = 32'hefcdab89;
    localparam logic [WORD_W-1:0] INIT_C = 32'h98badcfe;
    localparam logic [WORD_W-1:0] INIT_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [7:0] ZERO_BYTE = 8'h00;

    // Per-round additive constant
    function automatic logic [31:0] round_k(input logic [5:0] idx);
        case (idx)
            6'd0:  return 32'hd76aa478;
            6'd1:  return 32'he8c7b756;
            6'd2:  return 32'h242070db;
            6'd3:  return 32'hc1bdceee;
            6'd4:  return 32'hf57c0faf;
            6'd5:  return 32'h4787c62a;
            6'd6:  return 32'ha8304613;
            6'd7:  return 32'hfd469501;
            6'd8:  return 32'h698098d8;
            6'd9:  return 32'h8b44f7af;
            6'd10: return 32'hffff5bb1;
            6'd11: return 32'h895cd7be;
            6'd12: return 32'h6b901122;
            6'd13: return 32'hfd987193;
            6'd14: return 32'ha679438e;
            6'd15: return 32'h49b40821;
            6'd16: return 32'hf61e2562;
            6'd17: return 32'hc040b340;
            6'd18: return 32'h265e5a51;
            6'd19: return 32'he9b6c7aa;
            6'd20: return 32'hd62f105d;
            6'd21: return 32'h02441453;
            6'd22: return 32'hd8a1e681;
            6'd23: return 32'he7d3fbc8;
            6'd24: return 32'h21e1cde6;
            6'd25: return 32'hc33707d6;
            6'd26: return 32'hf4d50d87;
            6'd27: return 32'h455a14ed;
            6'd28: return 32'ha9e3e905;
            6'd29: return 32'hfcefa3f8;
            6'd30: return 32'h676f02d9;
            6'd31: return 32'h8d2a4c8a;
            6'd32: return 32'hfffa3942;
            6'd33: return 32'h8771f681;
            6'd34: return 32'h6d9d6122;
            6'd35: return 32'hfde5380c;
            6'd36: return 32'ha4beea44;
            6'd37: return 32'h4bdecfa9;
            6'd38: return 32'hf6bb4b60;
            6'd39: return 32'hbebfbc70;
            6'd40: return 32'h289b7ec6;
            6'd41: return 32'heaa127fa;
            6'd42: return 32'hd4ef3085;
            6'd43: return 32'h04881d05;
            6'd44: return 32'hd9d4d039;
            6'd45: return 32'he6db99e5;
            6'd46: return 32'h1fa27cf8;
            6'd47: return 32'hc4ac5665;
            6'd48: return 32'hf4292244;
            6'd49: return 32'h432aff97;
            6'd50: return 32'hab9423a7;
            6'd51: return 32'hfc93a039;
            6'd52: return 32'h655b59c3;
            6'd53: return 32'h8f0ccc92;
            6'd54: return 32'hffeff47d;
            6'd55: return 32'h85845dd1;
            6'd56: return 32'h6fa87e4f;
            6'd57: return 32'hfe2ce6e0;
            6'd58: return 32'ha3014314;
            6'd59: return 32'h4e0811a1;
            6'd60: return 32'hf7537e82;
            6'd61: return 32'hbd3af235;
            6'd62: return 32'h2ad7d2bb;
            default: return 32'heb86d391;
        endcase
    endfunction

    // Left-rotate amount, set by round group and round mod 4
    function automatic logic [4:0] round_rot(input logic [5:0] idx);
        case ({idx[5:4], idx[1:0]})
            4'd0:  return 5'd7;
            4'd1:  return 5'd12;
            4'd2:  return 5'd17;
            4'd3:  return 5'd22;
            4'd4:  return 5'd5;
            4'd5:  return 5'd9;
            4'd6:  return 5'd14;
            4'd7:  return 5'd20;
            4'd8:  return 5'd4;
            4'd9:  return 5'd11;
            4'd10: return 5'd16;
            4'd11: return 5'd23;
            4'd12: return 5'd6;
            4'd13: return 5'd10;
            4'd14: return 5'd15;
            default: return 5'd21;
        endcase
    endfunction

    // Message word used in a round (all arithmetic mod 16)
    function automatic logic [3:0] round_word(input logic [5:0] idx);
        case (idx[5:4])
            2'd0:    return idx[3:0];
            2'd1:    return 4'({idx[1:0], 2'b00} + idx[3:0] + 4'd1);
            2'd2:    return 4'({idx[2:0], 1'b0} + idx[3:0] + 4'd5);
            default: return 4'({idx[0], 3'b000} - idx[3:0]);
        endcase
    endfunction

    function automatic logic [31:0] round_f(input logic [5:0] idx, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        case (idx[5:4])
            2'd0:    return (b & c) | (~b & d);
            2'd1:    return (d & b) | (~d & c);
            2'd2:    return b ^ c ^ d;
            default: return c ^ (b | ~d);
        endcase
    endfunction

endpackage

### sv/md5_in_if.sv
interface md5_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output has_byte,
                    output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input has_byte,
                    input end_of_message, output ready);
endinterface

### sv/md5_out_if.sv
interface md5_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

### sv/md5_digest_engine.sv
// Channel  Dir  Contents
// msg      in   data_byte[7:0], has_byte, end_of_message
// digest   out  digest_word[31:0], word_index[1:0], last_word
//
// A byte transfer is taken in idle; a byte that fills a block starts a compression
// (64 rounds through the one round unit, then the chaining add).
// End of message: padding bytes up to offset 56, then the length, a compression
// for each block, then four digest transfers.
// msg.ready is high only in idle; digest stalls hold the word in place.
// rst_n clears control and loads the initial chaining words.
module md5_digest_engine (
    input  logic             clk,
    input  logic             rst_n,
    md5_in_if.sink           msg,
    md5_out_if.source        digest
);

    md5_pkg::state_t state_reg, state_next;

    logic [md5_pkg::COUNT_W-1:0] cnt_reg, cnt_next;
    logic [5:0]  pad_pos_reg, pad_pos_next;
    logic        first_pad_reg, first_pad_next;
    logic        pend_reg, pend_next;
    logic        final_reg, final_next;
    logic [5:0]  round_reg, round_next;
    logic [1:0]  idx_reg, idx_next;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] a_next, b_next, c_next, d_next;
    logic [31:0] chain_reg [4];
    logic [31:0] chain_next [4];

    // message block, bytes packed little-endian
    logic [31:0] block_mem [16];

    logic        byte_we;
    logic [5:0]  byte_pos;
    logic [7:0]  byte_val;
    logic        len_we;
    logic [63:0] bit_len;

    logic [31:0] f_sum;
    logic [63:0] rot_w;
    logic [31:0] b_new;

    assign bit_len = {cnt_reg, 3'b000};

    // shared round unit
    assign f_sum = md5_pkg::round_f(round_reg, b_reg, c_reg, d_reg) + a_reg
                   + md5_pkg::round_k(round_reg) + block_mem[md5_pkg::round_word(round_reg)];
    assign rot_w = {f_sum, f_sum} << md5_pkg::round_rot(round_reg);
    assign b_new = b_reg + rot_w[63:32];

    assign digest.digest_word = chain_reg[idx_reg];
    assign digest.word_index  = idx_reg;
    assign digest.last_word   = (idx_reg == 2'd3);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pad_pos_next   = pad_pos_reg;
        first_pad_next = first_pad_reg;
        pend_next      = pend_reg;
        final_next     = final_reg;
        round_next     = round_reg;
        idx_next       = idx_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        chain_next     = chain_reg;
        byte_we        = 1'b0;
        byte_pos       = pad_pos_reg;
        byte_val       = md5_pkg::ZERO_BYTE;
        len_we         = 1'b0;
        msg.ready      = 1'b0;
        digest.valid   = 1'b0;

        case (state_reg)
            md5_pkg::ST_IDLE:
            begin
                msg.ready = 1'b1;
                if (msg.valid)
                begin
                    if (msg.has_byte)
                    begin
                        byte_we  = 1'b1;
                        byte_pos = cnt_reg[5:0];
                        byte_val = msg.data_byte;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    pad_pos_next   = cnt_next[5:0];
                    first_pad_next = 1'b1;
                    pend_next      = msg.end_of_message;
                    if (msg.has_byte && cnt_reg[5:0] == 6'd63)
                    begin
                        state_next = md5_pkg::ST_ROUND;
                        a_next     = chain_reg[0];
                        b_next     = chain_reg[1];
                        c_next     = chain_reg[2];
                        d_next     = chain_reg[3];
                    end
                    else if (msg.end_of_message)
                    begin
                        state_next = md5_pkg::ST_PAD;
                    end
                end
            end

            md5_pkg::ST_PAD:
            begin
                byte_we        = 1'b1;
                byte_val       = first_pad_reg ? md5_pkg::PAD_BYTE : md5_pkg::ZERO_BYTE;
                first_pad_next = 1'b0;
                pad_pos_next   = pad_pos_reg + 6'd1;
                if (pad_pos_reg == 6'd63)
                begin
                    state_next = md5_pkg::ST_ROUND;
                    a_next     = chain_reg[0];
                    b_next     = chain_reg[1];
                    c_next     = chain_reg[2];
                    d_next     = chain_reg[3];
                end
                else if (pad_pos_reg == 6'd55)
                begin
                    state_next = md5_pkg::ST_LEN;
                end
            end

            md5_pkg::ST_LEN:
            begin
                len_we     = 1'b1;
                final_next = 1'b1;
                state_next = md5_pkg::ST_ROUND;
                a_next     = chain_reg[0];
                b_next     = chain_reg[1];
                c_next     = chain_reg[2];
                d_next     = chain_reg[3];
            end

            md5_pkg::ST_ROUND:
            begin
                a_next     = d_reg;
                d_next     = c_reg;
                c_next     = b_reg;
                b_next     = b_new;
                round_next = round_reg + 6'd1;
                if (round_reg == 6'd63)
                    state_next = md5_pkg::ST_ADD;
            end

            md5_pkg::ST_ADD:
            begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                if (final_reg)
                begin
                    state_next = md5_pkg::ST_OUT;
                    idx_next   = 2'd0;
                end
                else if (pend_reg)
                    state_next = md5_pkg::ST_PAD;
                else
                    state_next = md5_pkg::ST_IDLE;
            end

            md5_pkg::ST_OUT:
            begin
                digest.valid = 1'b1;
                if (digest.ready)
                begin
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == 2'd3)
                    begin
                        // restart for the next message
                        chain_next[0] = md5_pkg::INIT_A;
                        chain_next[1] = md5_pkg::INIT_B;
                        chain_next[2] = md5_pkg::INIT_C;
                        chain_next[3] = md5_pkg::INIT_D;
                        cnt_next      = '0;
                        pend_next     = 1'b0;
                        final_next    = 1'b0;
                        state_next    = md5_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = md5_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= md5_pkg::ST_IDLE;
            cnt_reg       <= '0;
            pad_pos_reg   <= '0;
            first_pad_reg <= 1'b0;
            pend_reg      <= 1'b0;
            final_reg     <= 1'b0;
            round_reg     <= '0;
            idx_reg       <= '0;
            chain_reg[0]  <= md5_pkg::INIT_A;
            chain_reg[1]  <= md5_pkg::INIT_B;
            chain_reg[2]  <= md5_pkg::INIT_C;
            chain_reg[3]  <= md5_pkg::INIT_D;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pad_pos_reg   <= pad_pos_next;
            first_pad_reg <= first_pad_next;
            pend_reg      <= pend_next;
            final_reg     <= final_next;
            round_reg     <= round_next;
            idx_reg       <= idx_next;
            chain_reg     <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
    end

    always_ff @(posedge clk)
    begin
        if (byte_we)
            block_mem[byte_pos[5:2]][{byte_pos[1:0], 3'b000} +: 8] <= byte_val;
        if (len_we)
        begin
            block_mem[14] <= bit_len[31:0];
            block_mem[15] <= bit_len[63:32];
        end
    end

`ifndef SYNTH
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(msg.ready && digest.valid))
        else $error("input ready while digest pending");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        digest.valid && digest.ready && digest.last_word |=> msg.ready && cnt_reg == '0)
        else $error("engine not restarted after last digest word");

    a_round_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != md5_pkg::ST_ROUND |-> round_reg == 6'd0)
        else $error("round counter not at zero outside compression");

    a_pad_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == md5_pkg::ST_LEN |-> pad_pos_reg == 6'd56 && pend_reg)
        else $error("length written at wrong block offset");
`endif

endmodule

### tb/md5_digest_engine_tb.sv
module md5_digest_engine_tb;

    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int MIN_ITEMS = 250;
    localparam int MIN_MSGS = 14;
    localparam int DIR_ROWS = 12;

    // digests as {A, B, C, D}, each word little-endian as held by the block
    localparam logic [127:0] DIG_EMPTY = {32'hd98c1dd4, 32'h04b2008f, 32'h980980e9, 32'h7e42f8ec};
    localparam logic [127:0] DIG_A     = {32'hb975c10c, 32'ha8b6f1c0, 32'he299c331, 32'h61267769};
    localparam logic [127:0] DIG_ABC   = {32'h98500190, 32'hb04fd23c, 32'h7d3f96d6, 32'h727fe128};

    // per-round additive constants, round 0 in the top word
    localparam logic [64*32-1:0] ROUND_ADD = {
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // rotate amounts indexed by {round group, round mod 4}
    localparam logic [16*5-1:0] ROT_AMT = {
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    typedef struct packed {
        logic [md5_pkg::WORD_W-1:0] word;
        logic [1:0]                 idx;
        logic                       last;
    } digest_beat_t;

    typedef struct packed {
        logic [7:0]   data;
        logic         has;
        logic         eom;
        logic         typed;
        logic [127:0] digest;
    } dir_row_t;

    logic clk;
    logic rst_n;

    md5_in_if  msg_ch ();
    md5_out_if dig_ch ();

    md5_digest_engine DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_ch),
        .digest (dig_ch)
    );

    // predictor state
    logic [md5_pkg::WORD_W-1:0]  chain_w [4];
    logic [md5_pkg::WORD_W-1:0]  blk_w [16];
    logic [md5_pkg::COUNT_W-1:0] byte_cnt;

    digest_beat_t digest_q [$];
    dir_row_t     dir_tab [DIR_ROWS];

    int err_cnt;
    int items_sent;
    int beats_seen;
    int cycle_cnt = 0;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic void md5_compress();
        logic [31:0] a, b, c, d, f, sum;
        int g;
        int rot;
        a = chain_w[0];
        b = chain_w[1];
        c = chain_w[2];
        d = chain_w[3];
        for (int i = 0; i < 64; i++)
        begin
            case (i / 16)
                0:
                begin
                    f = (b & c) | (~b & d);
                    g = i;
                end
                1:
                begin
                    f = (d & b) | (~d & c);
                    g = (5 * i + 1) % 16;
                end
                2:
                begin
                    f = b ^ c ^ d;
                    g = (3 * i + 5) % 16;
                end
                default:
                begin
                    f = c ^ (b | ~d);
                    g = (7 * i) % 16;
                end
            endcase
            sum = f + a + ROUND_ADD[(63 - i) * 32 +: 32] + blk_w[g];
            rot = ROT_AMT[(15 - ((i / 16) * 4 + (i % 4))) * 5 +: 5];
            a = d;
            d = c;
            c = b;
            b = b + ((sum << rot) | (sum >> (32 - rot)));
        end
        chain_w[0] = chain_w[0] + a;
        chain_w[1] = chain_w[1] + b;
        chain_w[2] = chain_w[2] + c;
        chain_w[3] = chain_w[3] + d;
    endfunction

    function automatic void put_byte(input logic [5:0] pos, input logic [7:0] val);
        blk_w[pos[5:2]][pos[1:0] * 8 +: 8] = val;
        if (pos == 6'd63)
            md5_compress();
    endfunction

    function automatic void chain_init();
        chain_w[0] = md5_pkg::INIT_A;
        chain_w[1] = md5_pkg::INIT_B;
        chain_w[2] = md5_pkg::INIT_C;
        chain_w[3] = md5_pkg::INIT_D;
        byte_cnt   = '0;
    endfunction

    // absorb one accepted transfer; at end of message queue the four digest words
    function automatic void md5_absorb(input logic [7:0] d, input logic h, input logic e,
                                       input logic typed, input logic [127:0] typed_dig);
        logic [63:0]  bitlen;
        logic [5:0]   pos;
        logic [127:0] dig;
        digest_beat_t beat;
        if (h)
        begin
            put_byte(byte_cnt[5:0], d);
            byte_cnt = byte_cnt + 1'b1;
        end
        if (e)
        begin
            bitlen = {byte_cnt, 3'b000};
            pos = byte_cnt[5:0];
            put_byte(pos, md5_pkg::PAD_BYTE);
            pos = pos + 1'b1;
            while (pos != 6'd56)
            begin
                put_byte(pos, md5_pkg::ZERO_BYTE);
                pos = pos + 1'b1;
            end
            blk_w[14] = bitlen[31:0];
            blk_w[15] = bitlen[63:32];
            md5_compress();
            dig = typed ? typed_dig : {chain_w[0], chain_w[1], chain_w[2], chain_w[3]};
            for (int k = 0; k < 4; k++)
            begin
                beat.word = dig[(3 - k) * 32 +: 32];
                beat.idx  = k[1:0];
                beat.last = (k == 3);
                digest_q.push_back(beat);
            end
            chain_init();
        end
    endfunction

    task automatic send_item(input logic [7:0] d, input logic h, input logic e,
                             input logic typed, input logic [127:0] typed_dig);
        logic idle_en;
        idle_en = !(items_sent >= 90 && items_sent < 150);
        while (idle_en && $urandom_range(99) < 9)
        begin
            msg_ch.valid <= 1'b0;
            @(negedge clk);
        end
        msg_ch.valid          <= 1'b1;
        msg_ch.data_byte      <= d;
        msg_ch.has_byte       <= h;
        msg_ch.end_of_message <= e;
        @(posedge clk);
        while (!msg_ch.ready)
            @(posedge clk);
        md5_absorb(d, h, e, typed, typed_dig);
        if (h || e)
            items_sent++;
        @(negedge clk);
    endtask

    // digest receiver
    initial
    begin
        int hold_left;
        logic hold_done;
        digest_beat_t want;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                dig_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (!hold_done && beats_seen >= 48)
            begin
                // long hold-off: the block sits on its output and stops taking bytes
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                dig_ch.ready <= 1'b0;
            end
            else if (beats_seen >= 24 && beats_seen < 44)
                dig_ch.ready <= 1'b1;
            else
                dig_ch.ready <= ($urandom_range(99) >= 9);
            @(posedge clk);
            if (dig_ch.valid && dig_ch.ready)
            begin
                beats_seen++;
                if (digest_q.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t unexpected digest transfer: expected none, actual %h idx %0d last %b",
                             $time, dig_ch.digest_word, dig_ch.word_index, dig_ch.last_word);
                end
                else
                begin
                    want = digest_q.pop_front();
                    if (dig_ch.digest_word !== want.word)
                    begin
                        err_cnt++;
                        $display("%0t digest_word mismatch: expected %h actual %h",
                                 $time, want.word, dig_ch.digest_word);
                    end
                    if (dig_ch.word_index !== want.idx)
                    begin
                        err_cnt++;
                        $display("%0t word_index mismatch: expected %0d actual %0d",
                                 $time, want.idx, dig_ch.word_index);
                    end
                    if (dig_ch.last_word !== want.last)
                    begin
                        err_cnt++;
                        $display("%0t last_word mismatch: expected %b actual %b",
                                 $time, want.last, dig_ch.last_word);
                    end
                end
            end
        end
    end

    // stimulus
    initial
    begin
        int len;
        int msgs;
        logic sep_end;
        rst_n                 = 1'b0;
        msg_ch.valid          = 1'b0;
        msg_ch.data_byte      = '0;
        msg_ch.has_byte       = 1'b0;
        msg_ch.end_of_message = 1'b0;
        dig_ch.ready          = 1'b0;
        err_cnt    = 0;
        items_sent = 0;
        beats_seen = 0;
        msgs       = 0;
        for (int i = 0; i < 16; i++)
            blk_w[i] = '0;
        chain_init();

        //              data   has   eom   typed digest
        dir_tab[0]  = {8'h00, 1'b0, 1'b1, 1'b1, DIG_EMPTY};  // empty message
        dir_tab[1]  = {8'h61, 1'b1, 1'b1, 1'b1, DIG_A};
        dir_tab[2]  = {8'h61, 1'b1, 1'b0, 1'b0, 128'h0};
        dir_tab[3]  = {8'hff, 1'b0, 1'b0, 1'b0, 128'h0};     // ignored byte
        dir_tab[4]  = {8'h62, 1'b1, 1'b0, 1'b0, 128'h0};
        dir_tab[5]  = {8'h63, 1'b1, 1'b1, 1'b1, DIG_ABC};
        dir_tab[6]  = {8'h61, 1'b1, 1'b0, 1'b0, 128'h0};
        dir_tab[7]  = {8'ha5, 1'b0, 1'b1, 1'b1, DIG_A};      // end without byte
        dir_tab[8]  = {8'h00, 1'b1, 1'b0, 1'b0, 128'h0};
        dir_tab[9]  = {8'hff, 1'b1, 1'b0, 1'b0, 128'h0};
        dir_tab[10] = {8'h5a, 1'b0, 1'b0, 1'b0, 128'h0};
        dir_tab[11] = {8'h80, 1'b1, 1'b1, 1'b0, 128'h0};

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
            send_item(dir_tab[r].data, dir_tab[r].has, dir_tab[r].eom,
                      dir_tab[r].typed, dir_tab[r].digest);

        while (items_sent < MIN_ITEMS || msgs < MIN_MSGS)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: len = $urandom_range(12);
                6:
                begin
                    // lengths around the one/two padding block boundary
                    case ($urandom_range(5))
                        0: len = 55;
                        1: len = 56;
                        2: len = 57;
                        3: len = 63;
                        4: len = 64;
                        default: len = 65;
                    endcase
                end
                7: len = $urandom_range(70, 13);
                default: len = $urandom_range(4);
            endcase
            sep_end = (len == 0) || ($urandom_range(9) < 3);
            for (int k = 0; k < len; k++)
            begin
                if ($urandom_range(9) == 0)
                    send_item(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, 128'h0);
                send_item(8'($urandom_range(255)), 1'b1, (k == len - 1) && !sep_end,
                          1'b0, 128'h0);
            end
            if (sep_end)
                send_item(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, 128'h0);
            msgs++;
            if (msgs == 6)
            begin
                // let the digest side drain fully before the next message
                while (digest_q.size() != 0)
                    @(negedge clk);
            end
        end
        msg_ch.valid <= 1'b0;

        while (digest_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
sv/md5_pkg.sv
sv/md5_in_if.sv
sv/md5_out_if.sv
sv/md5_digest_engine.sv
tb/md5_digest_engine_tb.sv
